// ----- rtl/slca_pkg.sv -----
// Shared constants and control types for the serial line and CSI assembler.
`timescale 1ns / 1ps

package slca_pkg;

    // Default sizes
    localparam int LINE_CAPACITY = 32;
    localparam int MAX_PARAMS    = 16;

    // Configuration register indexes
    localparam logic CFG_RX_NEWLINE  = 1'b0;
    localparam logic CFG_BINARY_MODE = 1'b1;

    // Character codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_PARAM_LO = 8'h30;
    localparam logic [7:0] CH_PARAM_HI = 8'h3F;
    localparam logic [7:0] CH_NUL      = 8'h00;

    // Escape parser stages
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_ESC  = 2'd1;
    localparam logic [1:0] SEQ_CSI  = 2'd2;

    // Result kinds
    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_SEQ  = 1'b1;

    // Datapath to controller
    typedef struct packed {
        logic line_go;    // byte on the input completes a line
        logic seq_go;     // byte on the input completes a sequence
        logic rd_last;    // drain index points at the final beat
        logic slot_free;  // output register can take a beat this cycle
    } t_dp_status;

    // Controller to datapath
    typedef struct packed {
        logic take;       // input beat accepted
        logic issue;      // move one beat into the output register
        logic mode_seq;   // draining a sequence rather than a line
    } t_ctrl_cmd;

endpackage

// ----- rtl/slca_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module slca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/slca_ctrl.sv -----
// Controller: accepts bytes and sequences the drain of lines and sequences.
`timescale 1ns / 1ps

module slca_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  slca_pkg::t_dp_status  i_status,
    output slca_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LINE = 2'd1;
    localparam logic [1:0] ST_SEQ  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_take;
    logic       w_issue;

    assign o_ready = (r_state == ST_IDLE);
    assign w_take  = i_valid && (r_state == ST_IDLE);
    assign w_issue = (r_state != ST_IDLE) && i_status.slot_free;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take && i_status.line_go) begin
                    n_state = ST_LINE;
                end else if (w_take && i_status.seq_go) begin
                    n_state = ST_SEQ;
                end
            end
            ST_LINE, ST_SEQ: begin
                if (w_issue && i_status.rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands
    assign o_cmd.take     = w_take;
    assign o_cmd.issue    = w_issue;
    assign o_cmd.mode_seq = (r_state == ST_SEQ);

endmodule

// ----- rtl/slca_dp.sv -----
// Datapath: byte decode, line and parameter stores, drain index, output register.
`timescale 1ns / 1ps

module slca_dp #(
    parameter int LINE_CAPACITY = slca_pkg::LINE_CAPACITY,
    parameter int MAX_PARAMS    = slca_pkg::MAX_PARAMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [1:0]            i_cfg_data,
    input  logic [7:0]            i_byte,
    input  logic                  i_out_ready,
    input  slca_pkg::t_ctrl_cmd   i_cmd,
    output slca_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output logic                  o_out_kind,
    output logic [7:0]            o_out_data,
    output logic                  o_out_last
);

    localparam int LAW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int PAW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW  = $clog2(MAX_PARAMS + 1);
    localparam int DW  = (LAW > CW) ? LAW : CW;

    // Configuration
    logic [1:0] r_rx_newline;
    logic       r_binary_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_newline  <= 2'd3;
            r_binary_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slca_pkg::CFG_RX_NEWLINE:  r_rx_newline  <= i_cfg_data;
                slca_pkg::CFG_BINARY_MODE: r_binary_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Parser state
    logic [LAW-1:0] r_len;
    logic [1:0]     r_nl;
    logic [1:0]     r_stage;
    logic [CW-1:0]  r_count;
    logic [7:0]     r_term;
    logic [DW-1:0]  r_idx;
    logic [DW-1:0]  r_drain_last;

    // Byte classification
    logic w_letter, w_param_ch, w_seq_open, w_seq_store, w_seq_end;
    logic w_to_line, w_ctrl, w_print, w_full, w_nl_match, w_line_go;
    logic [1:0] w_nl_next;
    logic [LAW-1:0] w_len_at;

    always_comb begin
        w_letter    = ((i_byte >= slca_pkg::CH_UPPER_A) && (i_byte <= slca_pkg::CH_UPPER_Z)) ||
                      ((i_byte >= slca_pkg::CH_LOWER_A) && (i_byte <= slca_pkg::CH_LOWER_Z));
        w_param_ch  = (i_byte >= slca_pkg::CH_PARAM_LO) && (i_byte <= slca_pkg::CH_PARAM_HI);
        w_seq_open  = (r_stage == slca_pkg::SEQ_ESC) && (i_byte == slca_pkg::CH_LBRACKET);
        w_seq_end   = (r_stage == slca_pkg::SEQ_CSI) && w_letter;
        w_seq_store = (r_stage == slca_pkg::SEQ_CSI) && !w_letter && w_param_ch &&
                      (r_count < CW'(MAX_PARAMS));
        w_to_line   = !(w_seq_open || w_seq_end || w_seq_store);
        w_ctrl      = w_to_line && (i_byte < slca_pkg::CH_SPACE) && !r_binary_mode;
        w_print     = w_to_line && !w_ctrl;
        w_full      = w_print && (r_len == LAW'(LINE_CAPACITY - 1));
        // line length once a backspace has taken effect
        w_len_at    = (w_ctrl && (i_byte == slca_pkg::CH_BS) && (r_len != '0)) ?
                      (r_len - LAW'(1)) : r_len;
        // newline pattern after this byte
        if (w_print) begin
            w_nl_next = 2'd0;
        end else if (w_ctrl && (i_byte == slca_pkg::CH_LF)) begin
            w_nl_next = r_nl | 2'd1;
        end else if (w_ctrl && (i_byte == slca_pkg::CH_CR)) begin
            w_nl_next = r_nl | 2'd2;
        end else begin
            w_nl_next = r_nl;
        end
        // sequence bytes never complete a line
        w_nl_match  = w_to_line && (r_rx_newline != 2'd0) && (w_nl_next == r_rx_newline);
        w_line_go   = w_full || w_nl_match;
    end

    // Parser state update on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_nl    <= 2'd0;
            r_stage <= slca_pkg::SEQ_NONE;
            r_count <= '0;
        end else if (i_cmd.take) begin
            if (w_line_go) begin
                r_len <= '0;
            end else if (w_print) begin
                r_len <= r_len + LAW'(1);
            end else if (w_ctrl && (i_byte == slca_pkg::CH_BS) && (r_len != '0)) begin
                r_len <= r_len - LAW'(1);
            end
            r_nl <= w_nl_match ? 2'd0 : w_nl_next;
            if (w_seq_open || w_seq_store) begin
                r_stage <= slca_pkg::SEQ_CSI;
            end else if (w_ctrl && (i_byte == slca_pkg::CH_ESC)) begin
                r_stage <= slca_pkg::SEQ_ESC;
            end else begin
                r_stage <= slca_pkg::SEQ_NONE;
            end
            r_count <= w_seq_store ? (r_count + CW'(1)) : '0;
        end
    end

    // Drain bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_idx        <= '0;
            r_drain_last <= w_seq_end ? DW'(r_count) : DW'(w_len_at);
            if (w_seq_end) begin
                r_term <= i_byte;
            end
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + DW'(1);
        end
    end

    // Line store
    logic       w_line_we;
    logic [7:0] w_line_wdata;
    logic [7:0] w_line_q;

    assign w_line_we    = i_cmd.take && (w_print || w_nl_match);
    assign w_line_wdata = (!w_print || (w_full && !r_binary_mode)) ? slca_pkg::CH_NUL : i_byte;

    slca_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (w_len_at),
        .i_wdata (w_line_wdata),
        .i_re    (i_cmd.issue && !i_cmd.mode_seq),
        .i_raddr (r_idx[LAW-1:0]),
        .o_rdata (w_line_q)
    );

    // Parameter store
    logic [7:0] w_param_q;

    slca_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PARAMS)
    ) u_param_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && w_seq_store),
        .i_waddr (r_count[PAW-1:0]),
        .i_wdata (i_byte),
        .i_re    (i_cmd.issue && i_cmd.mode_seq && !o_status.rd_last),
        .i_raddr (r_idx[PAW-1:0]),
        .o_rdata (w_param_q)
    );

    // Output register; RAM read registers hold the data of a waiting beat
    logic       r_out_valid;
    logic       r_out_kind;
    logic       r_out_last;
    logic       r_out_term;
    logic [7:0] r_term_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_out_kind <= i_cmd.mode_seq ? slca_pkg::KIND_SEQ : slca_pkg::KIND_LINE;
            r_out_last <= o_status.rd_last;
            r_out_term <= i_cmd.mode_seq && o_status.rd_last;
            r_term_out <= r_term;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = r_out_term ? r_term_out :
                         (r_out_kind == slca_pkg::KIND_SEQ) ? w_param_q : w_line_q;

    // Status
    assign o_status.line_go   = w_line_go;
    assign o_status.seq_go    = w_seq_end;
    assign o_status.rd_last   = (r_idx == r_drain_last);
    assign o_status.slot_free = !r_out_valid || i_out_ready;

endmodule

// ----- rtl/serial_line_and_csi_assembler.sv -----
// Top level of the serial line and CSI assembler.
`timescale 1ns / 1ps
//
// Received bytes enter one beat at a time on the s_axis channel. Lines and
// CSI escape sequences leave on the m_axis channel: tuser is the kind (0 line
// byte, 1 sequence byte), tdata the character and tlast marks the final beat
// of a line or sequence. Two configuration registers (newline pattern, binary
// mode) are to be written through i_cfg_we / i_cfg_idx / i_cfg_data while
// idle; the block does not enforce this. A byte that completes nothing is taken
// and the next byte may follow at once. A byte that completes a line of N bytes,
// or a sequence with N-1 parameters, occupies the input until its N result beats
// are issued: the controller enters its drain state, then moves one beat per
// cycle, while the receiver does not stall, into the output register. Line bytes
// and parameters come from RAM through a registered read port, the final
// sequence letter from a register. The last beat sits in the output register
// while the next byte is taken. A receiver stall holds the beat and pauses the
// drain; s_axis tready stays low until the drain is done. Reset (synchronous,
// active low) empties the line, clears the escape parser and any waiting beat,
// and restores the newline pattern to CR+LF and text mode.
module serial_line_and_csi_assembler #(
    parameter int LINE_CAPACITY = slca_pkg::LINE_CAPACITY,
    parameter int MAX_PARAMS    = slca_pkg::MAX_PARAMS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    // received bytes
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,    // [7:0] rx_byte
    // assembled output
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,    // [7:0] data
    output logic       o_m_axis_tuser,    // [0] kind
    output logic       o_m_axis_tlast
);

    slca_pkg::t_dp_status w_status;
    slca_pkg::t_ctrl_cmd  w_cmd;

    slca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    slca_dp #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .MAX_PARAMS    (MAX_PARAMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

// ----- bench/tb_line_sb_pkg.sv -----
// Scoreboard class for the serial line and CSI assembler bench: line predictor and beat checks.
`timescale 1ns / 1ps

package tb_line_sb_pkg;

    import slca_pkg::*;

    // newline_seen bits
    localparam logic [1:0] SEEN_LF = 2'b01;
    localparam logic [1:0] SEEN_CR = 2'b10;

    // one output beat as the block presents it
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    class line_scoreboard;

        t_out_beat   pending_beats[$];
        int          errors;

        // predicted block state
        logic [7:0]  line_chars [LINE_CAPACITY];
        int          line_len;
        logic [1:0]  nl_seen;
        logic [1:0]  seq_stage;
        logic [7:0]  seq_params [MAX_PARAMS];
        int          param_cnt;

        // predicted configuration
        logic [1:0]  nl_pattern;
        logic        raw_mode;

        function new();
            errors     = 0;
            line_len   = 0;
            nl_seen    = '0;
            seq_stage  = SEQ_NONE;
            param_cnt  = 0;
            nl_pattern = 2'd3;
            raw_mode   = 1'b0;
        endfunction

        function void set_newline(logic [1:0] pattern);
            nl_pattern = pattern;
        endfunction

        function void set_raw(logic raw);
            raw_mode = raw;
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction

        function void queue_beat(logic kind, logic [7:0] data, logic last);
            t_out_beat b;
            b.kind = kind;
            b.data = data;
            b.last = last;
            pending_beats.push_back(b);
        endfunction

        // whole line out, last flag on its final byte
        function void flush_line();
            for (int i = 0; i < line_len; i++)
                queue_beat(KIND_LINE, line_chars[i], (i + 1 == line_len));
            line_len = 0;
        endfunction

        // note an accepted byte and queue the beats it causes
        function void note_byte(logic [7:0] ch);
            bit to_line;
            bit letter;
            to_line = 1'b1;
            letter  = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
                      (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);

            // escape parser
            if (seq_stage == SEQ_ESC) begin
                if (ch == CH_LBRACKET) begin
                    seq_stage = SEQ_CSI;
                    to_line   = 1'b0;
                end else begin
                    seq_stage = SEQ_NONE;
                    param_cnt = 0;
                end
            end else if (seq_stage == SEQ_CSI) begin
                if (letter) begin
                    for (int i = 0; i < param_cnt; i++)
                        queue_beat(KIND_SEQ, seq_params[i], 1'b0);
                    queue_beat(KIND_SEQ, ch, 1'b1);
                    seq_stage = SEQ_NONE;
                    param_cnt = 0;
                    to_line   = 1'b0;
                end else if (param_cnt < MAX_PARAMS && ch >= CH_PARAM_LO &&
                             ch <= CH_PARAM_HI) begin
                    seq_params[param_cnt] = ch;
                    param_cnt++;
                    to_line = 1'b0;
                end else begin
                    seq_stage = SEQ_NONE;
                    param_cnt = 0;
                end
            end else if (seq_stage != SEQ_NONE) begin
                seq_stage = SEQ_NONE;
                param_cnt = 0;
            end

            if (!to_line)
                return;

            // line handling
            if (ch < CH_SPACE && !raw_mode) begin
                case (ch)
                    CH_BS:  if (line_len > 0) line_len--;
                    CH_LF:  nl_seen |= SEEN_LF;
                    CH_CR:  nl_seen |= SEEN_CR;
                    CH_ESC: seq_stage = SEQ_ESC;
                    default: ;
                endcase
            end else begin
                nl_seen = '0;
                if (line_len < LINE_CAPACITY) begin
                    line_chars[line_len] = ch;
                    line_len++;
                end
                // full line goes out at once
                if (line_len >= LINE_CAPACITY) begin
                    if (!raw_mode)
                        line_chars[LINE_CAPACITY-1] = CH_NUL;
                    line_len = LINE_CAPACITY;
                    flush_line();
                end
            end

            // newline match
            if (nl_pattern != 2'd0 && nl_seen == nl_pattern) begin
                if (line_len < LINE_CAPACITY) begin
                    line_chars[line_len] = CH_NUL;
                    line_len++;
                end
                nl_seen = '0;
                flush_line();
            end
        endfunction

        // compare an accepted output beat with the oldest expectation
        function void check_beat(logic kind, logic [7:0] data, logic last);
            t_out_beat exp_b;
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: kind %0d data 0x%02h last %0d", kind, data, last);
                errors++;
                return;
            end
            exp_b = pending_beats.pop_front();
            if (kind !== exp_b.kind) begin
                $error("kind mismatch: expected %0d, got %0d", exp_b.kind, kind);
                errors++;
            end
            if (data !== exp_b.data) begin
                $error("data mismatch: expected 0x%02h, got 0x%02h", exp_b.data, data);
                errors++;
            end
            if (last !== exp_b.last) begin
                $error("last mismatch: expected %0d, got %0d", exp_b.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- bench/tb_top.sv -----
// Top-level bench for the serial line and CSI assembler: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps

module tb_top;

    import slca_pkg::*;
    import tb_line_sb_pkg::*;

    localparam int ITEMS_PER_PHASE = 30;
    localparam int HOLD_CYCLES     = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = CFG_RX_NEWLINE;
    logic [1:0] cfg_data = '0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = '0;
    logic       m_ready = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [7:0] m_data;
    wire        m_kind;
    wire        m_last;

    line_scoreboard sb;
    int  bytes_sent = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    bit  hold_req = 1'b0;

    // settings of the random phases
    logic [1:0] patterns [7] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd0, 2'd1};
    logic       raws     [7] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

    logic [7:0] directed_bytes [] = '{
        CH_UPPER_A, CH_BS, CH_BS, CH_LOWER_Z, 8'hFF, CH_NUL, 8'h7F, CH_SPACE,
        CH_CR, CH_LF,
        CH_ESC, CH_LBRACKET, CH_PARAM_LO, CH_PARAM_HI, CH_UPPER_Z,
        CH_ESC, 8'h78,
        CH_ESC, CH_LBRACKET, 8'h35, 8'h2F,
        CH_LF, CH_CR,
        CH_ESC, CH_LBRACKET, CH_LOWER_A
    };

    serial_line_and_csi_assembler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // [7:0] rx_byte
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),     // [7:0] data
        .o_m_axis_tuser  (m_kind),     // [0] kind
        .o_m_axis_tlast  (m_last)
    );

    always #10 i_clk = ~i_clk;

    // check every accepted output beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid === 1'b1 && m_ready)
            sb.check_beat(m_kind, m_data, m_last);
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one byte, with an optional idle burst first, until it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (s_ready !== 1'b1);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // drop valid and wait until every expected beat has come
    task automatic drain_all();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // both registers, back to back, block idle
    task automatic write_config(input logic [1:0] pattern, input logic raw);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_RX_NEWLINE;
        cfg_data <= pattern;
        @(negedge i_clk);
        cfg_idx  <= CFG_BINARY_MODE;
        cfg_data <= {1'b0, raw};
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        sb.set_newline(pattern);
        sb.set_raw(raw);
    endtask

    // printable text, mostly short lines, now and then a full one
    task automatic send_text_line();
        int n;
        logic [7:0] ch;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 15))
                0:       ch = CH_BS;
                1, 2:    ch = 8'($urandom_range(8'h80, 8'hFF));
                default: ch = 8'($urandom_range(CH_SPACE, 8'h7E));
            endcase
            send_byte(ch);
        end
        case ($urandom_range(0, 3))
            0: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            1: send_byte(CH_LF);
            2: send_byte(CH_CR);
            default: begin
                send_byte(CH_LF);
                send_byte(CH_CR);
            end
        endcase
    endtask

    // CSI sequence, mostly well formed; sometimes too many params or broken
    task automatic send_csi();
        int n;
        logic [7:0] ch;
        send_byte(CH_ESC);
        send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_LBRACKET);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
        for (int k = 0; k < n; k++)
            send_byte(8'($urandom_range(CH_PARAM_LO, CH_PARAM_HI)));
        case ($urandom_range(0, 7))
            0:       ch = 8'($urandom_range(0, 255));
            1, 2, 3: ch = 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
            default: ch = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
        endcase
        send_byte(ch);
    endtask

    task automatic run_random(input int target);
        while (bytes_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_text_line();
                5, 6, 7:       send_csi();
                default: begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed bytes at reset defaults
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain_all();

        // random phases over several settings
        for (int p = 0; p < 7; p++) begin
            write_config(patterns[p], raws[p]);
            if (p == 2)
                hold_req = 1'b1;
            if (p == 6) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            run_random(bytes_sent + ITEMS_PER_PHASE);
            drain_all();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
